[rtl/lpht_pkg.sv]
// Shared types and constants of the linear probing hash table.
// Used by lpht_hash, lpht_datapath, lpht_ctrl and linear_probe_hash_table.
package lpht_pkg;

  localparam logic [63:0] MURMUR_M  = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] MURMUR_M8 = 64'h35253c9ade8f4ca8;
  localparam int unsigned MURMUR_R  = 47;

  typedef enum logic [1:0] {
    FUNC_SET  = 2'd0,
    FUNC_GET  = 2'd1,
    FUNC_DEL  = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_ZERO      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    clear_step;
    logic    load;
    logic    hash_start;
    logic    probe_init;
    logic    advance;
    logic    wr_set;
    logic    wr_del;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_set;
    status_t res_code;
    logic    res_take_value;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic  clear_last;
    logic  hash_done;
    func_t in_func;
    logic  in_key_zero;
    logic  in_value_zero;
    func_t func;
    logic  key_match;
    logic  slot_empty;
    logic  probe_last;
    logic  out_free;
  } sts_t;

endpackage

[rtl/linear_probe_hash_table.sv]
// Linear probing hash table, 64-bit keys and values, key 0 marks an empty slot.
// Top level: joins lpht_ctrl and lpht_datapath. Depends on lpht_pkg.
//
// One operation at a time. After reset the slot memory is cleared, one slot
// per cycle, with in_tready low. An operation with an unused func code, a zero
// key, or a zero value on a set is answered without hashing or probing. Otherwise
// the start slot comes from four 64-bit multiplies on one 32x32 multiplier,
// then reduction modulo TABLE_SIZE by reciprocal multiplication, then a hand-off,
// and each probed slot takes a registered memory read and a compare, up to
// TABLE_SIZE probes. The result register frees the output side: a waiting
// result only holds the next result, not the next accept.
module linear_probe_hash_table #(
  parameter int unsigned TABLE_SIZE = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // key[63:0], value[127:64]
  input  logic [1:0]   in_tuser,   // func[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata,  // read_value[63:0], item_count[74:64], zero[79:75]
  output logic [1:0]   out_tuser,  // status[1:0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [63:0]  cfg_data    // hash_seed
);

  localparam int unsigned IDXW = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned CW   = $clog2(TABLE_SIZE + 1);

  lpht_pkg::cmd_t cmd;
  lpht_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpht_datapath #(.TABLE_SIZE(TABLE_SIZE), .IDXW(IDXW), .CW(CW)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/lpht_hash.sv]
// Start-slot unit: MurmurHash64A of one 64-bit word on a shared 32x32 multiplier,
// then reduction modulo the table size by reciprocal multiplication. Depends on lpht_pkg.
module lpht_hash #(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned IDXW       = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [63:0]     key,
  input  logic [63:0]     seed,
  output logic            done,
  output logic [IDXW-1:0] slot
);

  localparam int unsigned RW = IDXW + 1;
  localparam int unsigned QW = 2 * RW;
  localparam logic [RW-1:0] TS = RW'(TABLE_SIZE);
  localparam logic [64:0] TWO64 = {1'b1, 64'h0};
  localparam logic [63:0] INV = 64'(TWO64 / 65'(TABLE_SIZE));
  localparam logic [31:0] M_LO = lpht_pkg::MURMUR_M[31:0];
  localparam logic [31:0] M_HI = lpht_pkg::MURMUR_M[63:32];
  localparam logic [31:0] INV_LO = INV[31:0];
  localparam logic [31:0] INV_HI = INV[63:32];

  logic          busy_r, busy_nxt;
  logic          mod_r, mod_nxt;
  logic [1:0]    stage_r, stage_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [63:0]   x_r, x_nxt;
  logic [63:0]   plo_r, plo_nxt;
  logic [31:0]   pmid_r, pmid_nxt;
  logic [127:0]  acc_r, acc_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic          done_r, done_nxt;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   pp;
  logic [31:0]   p_cross;
  logic [63:0]   prod;
  logic [63:0]   mixed;
  logic [QW-1:0] qt;

  always_comb begin
    mul_a = x_r[31:0];
    mul_b = M_LO;
    if (mod_r) begin
      mul_a = phase_r[1] ? x_r[63:32] : x_r[31:0];
      mul_b = phase_r[0] ? INV_HI : INV_LO;
    end else begin
      case (phase_r)
        3'd1:    mul_a = x_r[63:32];
        3'd2:    mul_b = M_HI;
        default: mul_a = x_r[31:0];
      endcase
    end
    pp      = 64'(mul_a) * 64'(mul_b);
    p_cross = pmid_r + pp[31:0];
    prod    = plo_r + {p_cross, 32'h0};
    mixed   = prod ^ (prod >> lpht_pkg::MURMUR_R);
    qt      = QW'(acc_r[64 +: RW]) * QW'(TS);
  end

  always_comb begin
    busy_nxt  = busy_r;
    mod_nxt   = mod_r;
    stage_nxt = stage_r;
    phase_nxt = phase_r;
    x_nxt     = x_r;
    plo_nxt   = plo_r;
    pmid_nxt  = pmid_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    if (start) begin
      busy_nxt  = 1'b1;
      mod_nxt   = 1'b0;
      stage_nxt = 2'd0;
      phase_nxt = 3'd0;
      x_nxt     = key;
    end else if (busy_r && !mod_r) begin
      case (phase_r)
        3'd0: begin
          plo_nxt   = pp;
          phase_nxt = 3'd1;
        end
        3'd1: begin
          pmid_nxt  = pp[31:0];
          phase_nxt = 3'd2;
        end
        default: begin
          phase_nxt = 3'd0;
          stage_nxt = stage_r + 2'd1;
          case (stage_r)
            2'd1:    x_nxt = (seed ^ lpht_pkg::MURMUR_M8) ^ prod;
            2'd3: begin
              x_nxt   = mixed;
              mod_nxt = 1'b1;
            end
            default: x_nxt = mixed;
          endcase
        end
      endcase
    end else if (busy_r) begin
      phase_nxt = phase_r + 3'd1;
      case (phase_r) inside
        3'd0:       acc_nxt = 128'(pp);
        3'd1, 3'd2: acc_nxt = acc_r + {32'h0, pp, 32'h0};
        3'd3:       acc_nxt = acc_r + {pp, 64'h0};
        3'd4:       rem_nxt = x_r[RW-1:0] - qt[RW-1:0];
        default: begin
          rem_nxt  = (rem_r >= TS) ? rem_r - TS : rem_r;
          busy_nxt = 1'b0;
          mod_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      mod_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      mod_r  <= mod_nxt;
      done_r <= done_nxt;
    end
    stage_r <= stage_nxt;
    phase_r <= phase_nxt;
    x_r     <= x_nxt;
    plo_r   <= plo_nxt;
    pmid_r  <= pmid_nxt;
    acc_r   <= acc_nxt;
    rem_r   <= rem_nxt;
  end

  assign done = done_r;
  assign slot = rem_r[IDXW-1:0];

endmodule

[rtl/lpht_datapath.sv]
// Datapath: slot memory, seed register, probe pointer, occupancy count and result registers.
// Depends on lpht_pkg and lpht_hash.
module lpht_datapath #(
  parameter int unsigned TABLE_SIZE = 1024,
  parameter int unsigned IDXW       = 10,
  parameter int unsigned CW         = 11
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lpht_pkg::cmd_t cmd,
  output lpht_pkg::sts_t sts,
  input  logic [1:0]     in_tuser,
  input  logic [127:0]   in_tdata,
  input  logic           cfg_valid,
  input  logic [63:0]    cfg_data,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [79:0]    out_tdata,
  output logic [1:0]     out_tuser
);

  localparam logic [IDXW-1:0] LAST = IDXW'(TABLE_SIZE - 1);

  logic [127:0]    mem [TABLE_SIZE];
  logic [127:0]    rdata_r;
  logic [63:0]     seed_r;
  logic [63:0]     key_r;
  logic [63:0]     val_r;
  lpht_pkg::func_t func_r;
  logic [IDXW-1:0] clr_r;
  logic [IDXW-1:0] slot_r;
  logic [IDXW-1:0] n_r;
  logic [CW-1:0]   cnt_r;
  logic [63:0]     res_val_r;
  lpht_pkg::status_t res_code_r;
  logic            ovalid_r;
  logic [63:0]     oval_r;
  logic [1:0]      ostat_r;
  logic [10:0]     ocnt_r;
  logic            hash_done;
  logic [IDXW-1:0] hash_slot;
  logic            wr_en;
  logic [IDXW-1:0] wr_addr;
  logic [127:0]    wr_data;

  lpht_hash #(.TABLE_SIZE(TABLE_SIZE), .IDXW(IDXW)) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.hash_start),
    .key   (in_tdata[63:0]),
    .seed  (seed_r),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  always_comb begin
    wr_en   = cmd.clear_step | cmd.wr_set | cmd.wr_del;
    wr_addr = cmd.clear_step ? clr_r : slot_r;
    wr_data = cmd.wr_set ? {val_r, key_r} : 128'h0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= '0;
      clr_r    <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_valid) seed_r <= cfg_data;
      if (cmd.clear_step) clr_r <= clr_r + IDXW'(1);
      if (cmd.cnt_inc) cnt_r <= cnt_r + CW'(1);
      else if (cmd.cnt_dec && cnt_r != '0) cnt_r <= cnt_r - CW'(1);
      if (cmd.out_load) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
    if (cmd.load) begin
      key_r  <= in_tdata[63:0];
      val_r  <= in_tdata[127:64];
      func_r <= lpht_pkg::func_t'(in_tuser);
    end
    if (cmd.probe_init) begin
      slot_r <= hash_slot;
      n_r    <= '0;
    end else if (cmd.advance) begin
      slot_r <= (slot_r == LAST) ? '0 : slot_r + IDXW'(1);
      n_r    <= n_r + IDXW'(1);
    end
    if (cmd.res_set) begin
      res_code_r <= cmd.res_code;
      res_val_r  <= cmd.res_take_value ? rdata_r[127:64] : 64'h0;
    end
    if (cmd.out_load) begin
      oval_r  <= res_val_r;
      ostat_r <= res_code_r;
      ocnt_r  <= 11'(cnt_r);
    end
  end

  always_comb begin
    sts.clear_last    = (clr_r == LAST);
    sts.hash_done     = hash_done;
    sts.in_func       = lpht_pkg::func_t'(in_tuser);
    sts.in_key_zero   = (in_tdata[63:0] == 64'h0);
    sts.in_value_zero = (in_tdata[127:64] == 64'h0);
    sts.func          = func_r;
    sts.key_match     = (rdata_r[63:0] == key_r);
    sts.slot_empty    = (rdata_r[63:0] == 64'h0);
    sts.probe_last    = (n_r == LAST);
    sts.out_free      = !ovalid_r || out_tready;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'h0, ocnt_r, oval_r};
  assign out_tuser  = ostat_r;

endmodule

[rtl/lpht_ctrl.sv]
// Controller: sequences memory clearing, hashing, probing and result hand-off.
// Depends on lpht_pkg.
module lpht_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  lpht_pkg::sts_t sts,
  output lpht_pkg::cmd_t cmd
);

  lpht_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpht_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      lpht_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_nxt = lpht_pkg::ST_IDLE;
      end
      lpht_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts.in_func == lpht_pkg::FUNC_NONE) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = lpht_pkg::STS_OK;
            state_nxt    = lpht_pkg::ST_DONE;
          end else if (sts.in_key_zero ||
                       (sts.in_func == lpht_pkg::FUNC_SET && sts.in_value_zero)) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = lpht_pkg::STS_ZERO;
            state_nxt    = lpht_pkg::ST_DONE;
          end else begin
            cmd.hash_start = 1'b1;
            state_nxt      = lpht_pkg::ST_HASH;
          end
        end
      end
      lpht_pkg::ST_HASH: begin
        if (sts.hash_done) begin
          cmd.probe_init = 1'b1;
          state_nxt      = lpht_pkg::ST_READ;
        end
      end
      lpht_pkg::ST_READ: begin
        state_nxt = lpht_pkg::ST_CMP;
      end
      lpht_pkg::ST_CMP: begin
        state_nxt = lpht_pkg::ST_DONE;
        cmd.res_set = 1'b1;
        unique case (sts.func)
          lpht_pkg::FUNC_SET: begin
            if (sts.key_match || sts.slot_empty) begin
              cmd.wr_set   = 1'b1;
              cmd.cnt_inc  = !sts.key_match;
              cmd.res_code = lpht_pkg::STS_OK;
            end else if (sts.probe_last) begin
              cmd.res_code = lpht_pkg::STS_FULL;
            end else begin
              cmd.res_set = 1'b0;
              cmd.advance = 1'b1;
              state_nxt   = lpht_pkg::ST_READ;
            end
          end
          lpht_pkg::FUNC_GET: begin
            if (sts.key_match) begin
              cmd.res_code       = lpht_pkg::STS_OK;
              cmd.res_take_value = 1'b1;
            end else if (sts.slot_empty || sts.probe_last) begin
              cmd.res_code = lpht_pkg::STS_NOT_FOUND;
            end else begin
              cmd.res_set = 1'b0;
              cmd.advance = 1'b1;
              state_nxt   = lpht_pkg::ST_READ;
            end
          end
          default: begin
            if (sts.key_match) begin
              cmd.wr_del   = 1'b1;
              cmd.cnt_dec  = 1'b1;
              cmd.res_code = lpht_pkg::STS_OK;
            end else if (sts.probe_last) begin
              cmd.res_code = lpht_pkg::STS_NOT_FOUND;
            end else begin
              cmd.res_set = 1'b0;
              cmd.advance = 1'b1;
              state_nxt   = lpht_pkg::ST_READ;
            end
          end
        endcase
      end
      lpht_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = lpht_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lpht_pkg::ST_IDLE;
    endcase
  end

endmodule

[test/tb.sv]
// Testbench of linear_probe_hash_table: directed table, random phases, full-table phase.
// Checks results against an in-bench table predictor or typed rows. Depends on lpht_pkg.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TSIZE    = 1024;
  localparam int          WDOG_MAX = 20000;

  typedef struct packed {
    logic [63:0]       rv;
    lpht_pkg::status_t status;
    logic [10:0]       count;
  } result_t;

  typedef struct {
    lpht_pkg::func_t f;
    logic [63:0]     key;
    logic [63:0]     value;
    bit              typed;
    result_t         res;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [79:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [63:0]  cfg_data = '0;

  linear_probe_hash_table #(.TABLE_SIZE(TSIZE)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [63:0] slot_key [TSIZE];
  logic [63:0] slot_val [TSIZE];
  int unsigned occupancy;
  logic [63:0] seed_reg;
  result_t     pending_results[$];
  int          errors;
  int          sent_items;
  int          got_results;
  int          idle_pct;
  int          stall_pct;
  int          wdog;
  logic [63:0] key_pool[40];

  function automatic logic [63:0] murmur_word(logic [63:0] k, logic [63:0] seed);
    logic [63:0] h;
    h = seed ^ 64'(lpht_pkg::MURMUR_M * 64'd8);
    k = k * lpht_pkg::MURMUR_M;
    k = k ^ (k >> lpht_pkg::MURMUR_R);
    k = k * lpht_pkg::MURMUR_M;
    h = h ^ k;
    h = h * lpht_pkg::MURMUR_M;
    h = h ^ (h >> lpht_pkg::MURMUR_R);
    h = h * lpht_pkg::MURMUR_M;
    h = h ^ (h >> lpht_pkg::MURMUR_R);
    return h;
  endfunction

  function automatic int unsigned home_slot(logic [63:0] k);
    return int'(murmur_word(k, seed_reg) % 64'(TSIZE));
  endfunction

  function automatic result_t table_op(lpht_pkg::func_t f, logic [63:0] k, logic [63:0] v);
    result_t     r;
    int unsigned s;
    r = '{rv: '0, status: lpht_pkg::STS_OK, count: '0};
    if (f == lpht_pkg::FUNC_NONE) begin
    end else if (k == 0 || (f == lpht_pkg::FUNC_SET && v == 0)) begin
      r.status = lpht_pkg::STS_ZERO;
    end else begin
      r.status = (f == lpht_pkg::FUNC_SET) ? lpht_pkg::STS_FULL : lpht_pkg::STS_NOT_FOUND;
      s = home_slot(k);
      for (int n = 0; n < TSIZE; n++) begin
        if (slot_key[s] == k) begin
          r.status = lpht_pkg::STS_OK;
          if (f == lpht_pkg::FUNC_SET) slot_val[s] = v;
          else if (f == lpht_pkg::FUNC_GET) r.rv = slot_val[s];
          else begin
            slot_key[s] = '0;
            slot_val[s] = '0;
            if (occupancy > 0) occupancy--;
          end
          break;
        end
        if (slot_key[s] == 0 && f != lpht_pkg::FUNC_DEL) begin
          if (f == lpht_pkg::FUNC_SET) begin
            slot_key[s] = k;
            slot_val[s] = v;
            occupancy++;
            r.status = lpht_pkg::STS_OK;
          end
          break;
        end
        s = (s + 1 >= TSIZE) ? 0 : s + 1;
      end
    end
    r.count = occupancy[10:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s at %0t: got %h expected %h", what, $realtime, got, want);
    errors++;
  endtask

  task automatic send_op(lpht_pkg::func_t f, logic [63:0] k, logic [63:0] v, bit typed = 0,
                         result_t want = '0);
    result_t r;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, k};
    in_tuser  <= f;
    do @(posedge clk); while (!in_tready);
    r = table_op(f, k, v);
    pending_results.push_back(typed ? want : r);
    sent_items++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] s);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    seed_reg = s;
  endtask

  // half the pool crowds the slots around the wrap point
  task automatic build_pool();
    logic [63:0] k;
    int unsigned s;
    for (int i = 0; i < 40; i++) begin
      do begin
        k = {$urandom, $urandom};
        s = home_slot(k);
      end while (k == 0 || (i < 20 && !(s >= TSIZE - 4 || s < 4)));
      key_pool[i] = k;
    end
  endtask

  task automatic random_phase(int n_items, int idle, int stall);
    int              p;
    lpht_pkg::func_t f;
    logic [63:0]     k;
    logic [63:0]     v;
    idle_pct  = idle;
    stall_pct = stall;
    build_pool();
    for (int i = 0; i < n_items; i++) begin
      p = $urandom_range(99);
      f = (p < 40) ? lpht_pkg::FUNC_SET : (p < 75) ? lpht_pkg::FUNC_GET :
          (p < 95) ? lpht_pkg::FUNC_DEL : lpht_pkg::FUNC_NONE;
      p = $urandom_range(99);
      k = (p < 5) ? 64'd0 : (p < 15) ? {$urandom, $urandom} : key_pool[$urandom_range(39)];
      v = ($urandom_range(99) < 5) ? 64'd0 : {$urandom, $urandom};
      send_op(f, k, v);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (out_tvalid && out_tready) begin
      got_results++;
      if (pending_results.size() == 0) begin
        report("unexpected result", out_tdata[63:0], 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[63:0] !== want.rv) report("read_value", out_tdata[63:0], want.rv);
        if (out_tuser !== want.status) report("status", 64'(out_tuser), 64'(want.status));
        if (out_tdata[74:64] !== want.count)
          report("item_count", 64'(out_tdata[74:64]), 64'(want.count));
        if (out_tdata[79:75] !== 5'd0) report("padding", 64'(out_tdata[79:75]), 64'd0);
      end
    end
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("watchdog expired with %0d results pending", pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  initial begin
    row_t        rows[$];
    logic [63:0] ones;
    logic [63:0] k;
    ones = '1;
    errors = 0;
    sent_items = 0;
    got_results = 0;
    idle_pct = 0;
    stall_pct = 0;
    wdog = 0;
    seed_reg = '0;
    occupancy = 0;
    foreach (slot_key[i]) begin
      slot_key[i] = '0;
      slot_val[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    rows = '{
      '{lpht_pkg::FUNC_GET,  64'd1, 64'd5,  1, '{64'd0, lpht_pkg::STS_NOT_FOUND, 11'd0}},
      '{lpht_pkg::FUNC_SET,  64'd0, 64'd5,  1, '{64'd0, lpht_pkg::STS_ZERO, 11'd0}},
      '{lpht_pkg::FUNC_SET,  64'd7, 64'd0,  1, '{64'd0, lpht_pkg::STS_ZERO, 11'd0}},
      '{lpht_pkg::FUNC_NONE, 64'd7, 64'd9,  1, '{64'd0, lpht_pkg::STS_OK, 11'd0}},
      '{lpht_pkg::FUNC_SET,  ones,  ones,   1, '{64'd0, lpht_pkg::STS_OK, 11'd1}},
      '{lpht_pkg::FUNC_GET,  ones,  64'd0,  1, '{ones,  lpht_pkg::STS_OK, 11'd1}},
      '{lpht_pkg::FUNC_GET,  64'd0, 64'd0,  1, '{64'd0, lpht_pkg::STS_ZERO, 11'd1}},
      '{lpht_pkg::FUNC_DEL,  64'd0, 64'd0,  1, '{64'd0, lpht_pkg::STS_ZERO, 11'd1}},
      '{lpht_pkg::FUNC_DEL,  ones,  64'd0,  1, '{64'd0, lpht_pkg::STS_OK, 11'd0}},
      '{lpht_pkg::FUNC_DEL,  ones,  64'd0,  1, '{64'd0, lpht_pkg::STS_NOT_FOUND, 11'd0}},
      '{lpht_pkg::FUNC_SET,  64'd1, 64'h5555555555555555, 0, '0},
      '{lpht_pkg::FUNC_SET,  64'd2, 64'haaaaaaaaaaaaaaaa, 0, '0},
      '{lpht_pkg::FUNC_SET,  64'd3, 64'd1, 0, '0},
      '{lpht_pkg::FUNC_SET,  64'h8000000000000000, ones, 0, '0},
      '{lpht_pkg::FUNC_GET,  64'd1, 64'd0, 0, '0},
      '{lpht_pkg::FUNC_GET,  64'd2, 64'd0, 0, '0},
      '{lpht_pkg::FUNC_SET,  64'd2, 64'h0123456789abcdef, 0, '0},
      '{lpht_pkg::FUNC_GET,  64'd2, 64'd0, 0, '0},
      '{lpht_pkg::FUNC_DEL,  64'd3, 64'd0, 0, '0},
      '{lpht_pkg::FUNC_GET,  64'd3, 64'd0, 0, '0},
      '{lpht_pkg::FUNC_SET,  64'd3, 64'd42, 0, '0},
      '{lpht_pkg::FUNC_NONE, ones, 64'd0, 0, '0},
      '{lpht_pkg::FUNC_GET,  64'h8000000000000000, ones, 0, '0}
    };
    write_seed(64'd0);
    foreach (rows[i]) send_op(rows[i].f, rows[i].key, rows[i].value, rows[i].typed,
                              rows[i].res);

    write_seed(ones);
    random_phase(40, 0, 0);
    write_seed({$urandom, $urandom});
    random_phase(40, 58, 0);
    write_seed({$urandom, $urandom});
    random_phase(40, 0, 58);
    write_seed(64'd0);
    random_phase(40, 14, 14);

    // fill to capacity, then hit full table, misses and holes
    write_seed({$urandom, $urandom});
    idle_pct = 14;
    stall_pct = 14;
    while (occupancy < TSIZE) begin
      do k = {$urandom, $urandom}; while (k == 0);
      send_op(lpht_pkg::FUNC_SET, k, {$urandom, $urandom});
    end
    for (int i = 0; i < 3; i++)
      send_op(lpht_pkg::FUNC_SET, {$urandom, $urandom} | 64'd1, 64'd3);
    for (int i = 0; i < 3; i++)
      send_op(lpht_pkg::FUNC_GET, {$urandom, $urandom} | 64'd1, 64'd0);
    for (int i = 0; i < 3; i++)
      send_op(lpht_pkg::FUNC_DEL, {$urandom, $urandom} | 64'd1, 64'd0);
    for (int i = 0; i < 20; i++) begin
      k = slot_key[$urandom_range(TSIZE - 1)];
      send_op(($urandom_range(1) == 0) ? lpht_pkg::FUNC_DEL : lpht_pkg::FUNC_GET, k, 64'd0);
      send_op(lpht_pkg::FUNC_GET, slot_key[$urandom_range(TSIZE - 1)], 64'd0);
      send_op(lpht_pkg::FUNC_SET, ($urandom_range(1) == 0) ? k : {$urandom, $urandom} | 64'd1,
              {$urandom, $urandom} | 64'd1);
    end

    drain();
    repeat (50) @(posedge clk);
    $display("%0d operations sent, %0d results checked over six phases", sent_items,
             got_results);
    $display("covered zero keys and values, overwrites, holes, full table and misses");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
